[rtl/quintic_trajectory_evaluator_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the quintic trajectory evaluator
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUINTIC_TRAJECTORY_EVALUATOR_TOP_ASSERT_SVH
`define QUINTIC_TRAJECTORY_EVALUATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QTE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qte: same-cycle check failed");
// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qte: next-cycle check failed");
`else
`define QTE_ASSERT_SAME(lbl, ante, cons)
`define QTE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/qte_pkg.sv]
// ---------------------------------------------------------------------------
// qte_pkg
// Widths, lane map, Horner multipliers and helpers shared by the evaluator.
// ---------------------------------------------------------------------------
package qte_pkg;

  localparam int TIME_W    = 32;  // unsigned Q2.30
  localparam int TIME_FRAC = 30;
  localparam int COEF_W    = 32;  // signed Q16.16
  localparam int WIDEN     = 8;   // Q16.16 -> 24 fraction bits
  localparam int OUT_W     = 48;  // signed Q24.24
  localparam int ACC_W     = 56;  // Horner accumulator
  localparam int LO_W      = 32;  // low partial product split
  localparam int PL_W      = LO_W + TIME_W;
  localparam int PH_W      = ACC_W - LO_W + TIME_W;
  localparam int SUM_W     = PH_W + LO_W + 1;
  localparam int MULT_W    = 5;

  localparam int LANES = 6;  // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
  localparam int SLOTS = 6;  // powers 5 down to 0
  localparam int STEPS = 5;  // Horner steps after the leading coefficient

  localparam int LANE_POS_X = 0;
  localparam int LANE_POS_Y = 1;
  localparam int LANE_VEL_X = 2;
  localparam int LANE_VEL_Y = 3;
  localparam int LANE_ACC_X = 4;
  localparam int LANE_ACC_Y = 5;

  localparam int KIND_POS = 0;
  localparam int KIND_VEL = 1;

  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_LSB   = 3;
  localparam logic [REG_IDX_W-1:0] NUM_REGS = REG_IDX_W'(SLOTS);

  // derivative factors per slot: (4-i+1) for velocity, (4-i+1)(3-i+1) for acceleration
  localparam logic [MULT_W-1:0] VEL_MUL [SLOTS] = '{5'd5, 5'd4, 5'd3, 5'd2, 5'd1, 5'd0};
  localparam logic [MULT_W-1:0] ACC_MUL [SLOTS] = '{5'd20, 5'd12, 5'd6, 5'd2, 5'd0, 5'd0};

  typedef struct packed {
    logic                         valid;
    logic [TIME_W-1:0]            time_q;
    logic [LANES-1:0][ACC_W-1:0]  acc;
  } qte_bus_t;

  function automatic logic [MULT_W-1:0] lane_mult(input int slot, input int lane);
    logic [MULT_W-1:0] m;
    case (lane >> 1)
      KIND_POS: m = MULT_W'(1);
      KIND_VEL: m = VEL_MUL[slot];
      default:  m = ACC_MUL[slot];
    endcase
    return m;
  endfunction

  // lanes that still run their chain at a given step
  function automatic logic [LANES-1:0] lane_en(input int step);
    logic [LANES-1:0] en;
    for (int l = 0; l < LANES; l++) begin
      en[l] = (lane_mult(step, l) != '0);
    end
    return en;
  endfunction

  // x sits in the upper half, y in the lower half
  function automatic logic [COEF_W-1:0] coef_half(input logic [DATA_W-1:0] word,
                                                   input int lane);
    logic [COEF_W-1:0] h;
    if ((lane & 1) == 0) begin
      h = word[DATA_W-1:COEF_W];
    end else begin
      h = word[COEF_W-1:0];
    end
    return h;
  endfunction

  // widen to 24 fraction bits and scale by a small constant
  function automatic logic [ACC_W-1:0] coef_scale(input logic [COEF_W-1:0] c,
                                                   input logic [MULT_W-1:0] m);
    logic [ACC_W-1:0] q;
    q = {{(ACC_W-COEF_W-WIDEN){c[COEF_W-1]}}, c, {WIDEN{1'b0}}};
    return ACC_W'(q * ACC_W'(m));
  endfunction

endpackage

[rtl/qte_if.sv]
// ---------------------------------------------------------------------------
// qte channel interfaces
// Time sample request channel and trajectory result channel.
// ---------------------------------------------------------------------------
interface qte_in_if import qte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_q;

  modport source (output valid, output time_q, input ready);
  modport sink   (input valid, input time_q, output ready);
endinterface

interface qte_out_if import qte_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pos_x;
  logic signed [OUT_W-1:0] pos_y;
  logic signed [OUT_W-1:0] vel_x;
  logic signed [OUT_W-1:0] vel_y;
  logic signed [OUT_W-1:0] acc_x;
  logic signed [OUT_W-1:0] acc_y;

  modport source (output valid, output pos_x, output pos_y, output vel_x,
                  output vel_y, output acc_x, output acc_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input vel_x,
                  input vel_y, input acc_x, input acc_y, output ready);
endinterface

[rtl/qte_horner_step.sv]
// ---------------------------------------------------------------------------
// qte_horner_step
// One Horner step acc' = addend + round(acc * t / 2^30) on LANE_EN lanes (rest
// keep acc), in four stages: magnitude, partial products, round, signed add.
// ---------------------------------------------------------------------------
`include "quintic_trajectory_evaluator_top_assert.svh"

module qte_horner_step import qte_pkg::*; #(
  parameter logic [5:0] LANE_EN = 6'b111111
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qte_bus_t                    up,
  output logic                        up_load,
  output qte_bus_t                    dn,
  input  logic                        dn_load,
  input  logic [LANES-1:0][ACC_W-1:0] addend
);

  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (TIME_FRAC - 1);

  logic va_r, vb_r, vc_r, vd_r;
  logic ld_a, ld_b, ld_c, ld_d;
  logic [TIME_W-1:0] ta_r, tb_r, tc_r, td_r;
  logic [LANES-1:0] nega_r, negb_r, negc_r, nega_nxt;
  logic [LANES-1:0][ACC_W-1:0] maga_r, maga_nxt;
  logic [LANES-1:0][ACC_W-1:0] holda_r, holdb_r, holdc_r;
  logic [LANES-1:0][PL_W-1:0]  plb_r, plb_nxt;
  logic [LANES-1:0][PH_W-1:0]  phb_r, phb_nxt;
  logic [LANES-1:0][SUM_W-1:0] sum_c;
  logic [LANES-1:0][ACC_W-1:0] rc_r, rc_nxt;
  logic [LANES-1:0][ACC_W-1:0] accd_r, accd_nxt;

  // a stage loads when it is empty or its contents move on
  assign ld_d    = !vd_r || dn_load;
  assign ld_c    = !vc_r || ld_d;
  assign ld_b    = !vb_r || ld_c;
  assign ld_a    = !va_r || ld_b;
  assign up_load = ld_a;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nega_nxt[l] = up.acc[l][ACC_W-1];
      maga_nxt[l] = nega_nxt[l] ? (~up.acc[l] + ACC_W'(1)) : up.acc[l];
      plb_nxt[l]  = PL_W'(maga_r[l][LO_W-1:0]) * PL_W'(ta_r);
      phb_nxt[l]  = PH_W'(maga_r[l][ACC_W-1:LO_W]) * PH_W'(ta_r);
      sum_c[l]    = SUM_W'({phb_r[l], {LO_W{1'b0}}}) + SUM_W'(plb_r[l]) + RND;
      rc_nxt[l]   = sum_c[l][TIME_FRAC +: ACC_W];
      if (LANE_EN[l]) begin
        accd_nxt[l] = negc_r[l] ? (addend[l] - rc_r[l]) : (addend[l] + rc_r[l]);
      end else begin
        accd_nxt[l] = holdc_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ld_a) va_r <= up.valid;
      if (ld_b) vb_r <= va_r;
      if (ld_c) vc_r <= vb_r;
      if (ld_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      ta_r    <= up.time_q;
      nega_r  <= nega_nxt;
      maga_r  <= maga_nxt;
      holda_r <= up.acc;
    end
    if (ld_b) begin
      tb_r    <= ta_r;
      negb_r  <= nega_r;
      plb_r   <= plb_nxt;
      phb_r   <= phb_nxt;
      holdb_r <= holda_r;
    end
    if (ld_c) begin
      tc_r    <= tb_r;
      negc_r  <= negb_r;
      rc_r    <= rc_nxt;
      holdc_r <= holdb_r;
    end
    if (ld_d) begin
      td_r   <= tc_r;
      accd_r <= accd_nxt;
    end
  end

  assign dn.valid  = vd_r;
  assign dn.time_q = td_r;
  assign dn.acc    = accd_r;

  // occupancy changes only by requests entering and leaving
  `QTE_ASSERT_NEXT(a_step_occupancy, 1'b1, $countones(({va_r, vb_r, vc_r, vd_r})) == $past($countones(({va_r, vb_r, vc_r, vd_r}))) + int'($past(ld_a && up.valid)) - int'($past(dn_load && vd_r)))
  `QTE_ASSERT_SAME(a_step_stall, !ld_a, va_r && vb_r && vc_r && vd_r && !dn_load)
  `QTE_ASSERT_NEXT(a_step_hold, vd_r && !dn_load, vd_r && $stable(accd_r))

endmodule

[rtl/quintic_trajectory_evaluator_top.sv]
// ---------------------------------------------------------------------------
// quintic_trajectory_evaluator_top
// Two-axis quintic trajectory: position, velocity and acceleration per sample.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per time sample, time_q in unsigned Q2.30 seconds.
//   out_ch : one result per request, pos/vel/acc for x and y, signed Q24.24,
//            saturated to 48 bits.
//   APB    : six 64-bit coefficient registers at byte offsets 0x00..0x28,
//            highest power first, x in bits 63:32 and y in bits 31:0 (Q16.16).
//            Writes take effect for requests accepted from the next cycle on.
// A request passes an input register, five Horner steps of four stages each
// (magnitude, 32x32 and 24x32 partial products, round, signed add) and the
// saturating output register. Throughput is one request per cycle while
// out_ch.ready is high; the five-step Horner pipeline sets the latency, the
// 32x32 partial product per stage sets the clock.
// Reset clears all coefficients and drops every request in flight.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// keeps taking requests until every stage holds one; nothing is dropped.
// ---------------------------------------------------------------------------
`include "quintic_trajectory_evaluator_top_assert.svh"

module quintic_trajectory_evaluator_top import qte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  qte_in_if.sink            in_ch,
  qte_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DATA_W-1:0] coef_r [SLOTS];
  logic [LANES-1:0][ACC_W-1:0] addend_r [SLOTS];
  logic cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  logic in_v_r, in_ld;
  logic [TIME_W-1:0] in_t_r;
  logic [STEPS:0] step_ld;
  qte_bus_t bus [STEPS+1];

  logic out_v_r, out_ld;
  logic [LANES-1:0][OUT_W-1:0] res_r, res_nxt;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:REG_LSB];
  assign prdata  = (cfg_idx < NUM_REGS) ? coef_r[cfg_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        coef_r[s] <= '0;
      end
    end else if (cfg_wr && (cfg_idx < NUM_REGS)) begin
      coef_r[cfg_idx] <= pwdata;
    end
  end

  // pre-scaled Horner addends, refreshed every cycle from the coefficients
  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        addend_r[s][l] <= coef_scale(coef_half(coef_r[s], l), lane_mult(s, l));
      end
    end
  end

  // input register
  assign in_ld       = !in_v_r || step_ld[0];
  assign in_ch.ready = in_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ld) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ld) in_t_r <= in_ch.time_q;
  end

  // the leading coefficient seeds every chain
  assign bus[0].valid  = in_v_r;
  assign bus[0].time_q = in_t_r;
  assign bus[0].acc    = addend_r[0];

  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    qte_horner_step #(
      .LANE_EN (lane_en(s))
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .up      (bus[s-1]),
      .up_load (step_ld[s-1]),
      .dn      (bus[s]),
      .dn_load (step_ld[s]),
      .addend  (addend_r[s])
    );
  end

  // saturate to 48 bits and hold for the receiver
  assign out_ld         = !out_v_r || out_ch.ready;
  assign step_ld[STEPS] = out_ld;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if ((&bus[STEPS].acc[l][ACC_W-1:OUT_W-1]) || !(|bus[STEPS].acc[l][ACC_W-1:OUT_W-1])) begin
        res_nxt[l] = bus[STEPS].acc[l][OUT_W-1:0];
      end else begin
        res_nxt[l] = {bus[STEPS].acc[l][ACC_W-1], {(OUT_W-1){~bus[STEPS].acc[l][ACC_W-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ld) begin
      out_v_r <= bus[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) res_r <= res_nxt;
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.pos_x = signed'(res_r[LANE_POS_X]);
  assign out_ch.pos_y = signed'(res_r[LANE_POS_Y]);
  assign out_ch.vel_x = signed'(res_r[LANE_VEL_X]);
  assign out_ch.vel_y = signed'(res_r[LANE_VEL_Y]);
  assign out_ch.acc_x = signed'(res_r[LANE_ACC_X]);
  assign out_ch.acc_y = signed'(res_r[LANE_ACC_Y]);

  // requests are refused only when every stage is full and the output waits
  `QTE_ASSERT_SAME(a_blocked_full, !in_ld, (step_ld == '0) && out_v_r && in_v_r)
  `QTE_ASSERT_NEXT(a_cfg_write, cfg_wr && (cfg_idx < NUM_REGS), coef_r[$past(cfg_idx)] == $past(pwdata))
  `QTE_ASSERT_NEXT(a_out_fill, out_ld && bus[STEPS].valid, out_v_r)

endmodule

[tb/quintic_trajectory_evaluator_top_test.sv]
// ---------------------------------------------------------------------------
// quintic_trajectory_evaluator_top_test
// Drives time samples into the two-axis quintic evaluator and checks every
// result against a fixed-point Horner predictor. A short directed script
// covers reset values, saturation, constant terms and ignored register
// writes. Random phases then reload all six coefficient registers and send
// random time samples under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module quintic_trajectory_evaluator_top_test import qte_pkg::*; ();

  localparam int COEF_SLOTS      = 6;
  localparam int REG_STRIDE      = 8;
  localparam int LATENCY_CYCLES  = 22;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int REPORT_LIMIT    = 10;

  localparam logic signed [OUT_W-1:0] SAT_HI  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] SAT_LO  = 48'sh8000_0000_0000;
  localparam logic signed [63:0]      WIDE_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0]      WIDE_LO = -WIDE_HI - 64'sd1;

  typedef enum logic [2:0] {
    COEF_POW5, COEF_POW4, COEF_POW3, COEF_POW2, COEF_POW1, COEF_POW0,
    COEF_SPARE6, COEF_SPARE7
  } coef_reg_e;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef enum logic [1:0] {
    FLOW_STEADY, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH
  } flow_mode_e;

  typedef enum logic [1:0] {STYLE_SMALL, STYLE_FULL, STYLE_MAX, STYLE_MIN} coef_style_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic signed [OUT_W-1:0] vel_x;
    logic signed [OUT_W-1:0] vel_y;
    logic signed [OUT_W-1:0] acc_x;
    logic signed [OUT_W-1:0] acc_y;
  } trajectory_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    trajectory_t       want;
  } pending_t;

  typedef struct packed {
    row_kind_e         kind;
    coef_reg_e         sel;
    logic [DATA_W-1:0] word;
    logic [TIME_W-1:0] t;
    logic              known;
    trajectory_t       want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  qte_in_if  in_ch ();
  qte_out_if out_ch ();

  quintic_trajectory_evaluator_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [DATA_W-1:0] coef_shadow [COEF_SLOTS];
  pending_t          expected_traj_q [$];
  directed_row_t     script [$];
  int                error_count = 0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** quintic_trajectory_evaluator_top: FAILED **");
    $finish;
  end

  // ---- predictor ----------------------------------------------------------

  // coefficient of power (5 - slot) as a Q.24 value
  function automatic logic signed [63:0] widen_coef(int slot, int axis);
    logic [COEF_W-1:0] half;
    half = (axis == 0) ? coef_shadow[slot][63:32] : coef_shadow[slot][31:0];
    return {{24{half[COEF_W-1]}}, half, 8'h00};
  endfunction

  // acc * t / 2^30, magnitude rounded half away from zero
  function automatic logic signed [63:0] scale_by_time(logic signed [63:0] acc,
                                                       logic [TIME_W-1:0] t);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [63:0]  r;
    mag  = acc[63] ? 64'(-acc) : 64'(acc);
    prod = {64'd0, mag} * {96'd0, t} + (128'd1 << 29);
    r    = prod[93:30];
    return acc[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_q24(logic signed [63:0] v);
    if (v > WIDE_HI) begin
      return SAT_HI;
    end else if (v < WIDE_LO) begin
      return SAT_LO;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic trajectory_t eval_trajectory(logic [TIME_W-1:0] t);
    logic signed [63:0]      p;
    logic signed [63:0]      v;
    logic signed [63:0]      a;
    logic signed [OUT_W-1:0] lane [6];
    trajectory_t             res;
    for (int axis = 0; axis < 2; axis++) begin
      p = widen_coef(0, axis);
      v = widen_coef(0, axis) * 64'sd5;
      a = widen_coef(0, axis) * 64'sd20;
      for (int k = 1; k < 6; k++) begin
        p = scale_by_time(p, t) + widen_coef(k, axis);
      end
      // derivative factors: power n contributes n and n*(n-1)
      for (int k = 1; k < 5; k++) begin
        v = scale_by_time(v, t) + widen_coef(k, axis) * longint'(5 - k);
      end
      for (int k = 1; k < 4; k++) begin
        a = scale_by_time(a, t) + widen_coef(k, axis) * longint'((5 - k) * (4 - k));
      end
      lane[axis]     = clamp_q24(p);
      lane[2 + axis] = clamp_q24(v);
      lane[4 + axis] = clamp_q24(a);
    end
    res = '{lane[0], lane[1], lane[2], lane[3], lane[4], lane[5]};
    return res;
  endfunction

  // ---- stimulus helpers ---------------------------------------------------

  function automatic directed_row_t row_write(coef_reg_e sel, logic [DATA_W-1:0] word);
    directed_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.sel  = sel;
    r.word = word;
    return r;
  endfunction

  function automatic directed_row_t row_sample(logic [TIME_W-1:0] t);
    directed_row_t r;
    r      = '0;
    r.kind = ROW_SAMPLE;
    r.t    = t;
    return r;
  endfunction

  function automatic directed_row_t row_check(logic [TIME_W-1:0] t, trajectory_t want);
    directed_row_t r;
    r       = row_sample(t);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic void set_flow(flow_mode_e mode);
    case (mode)
      FLOW_STEADY:      begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      FLOW_SRC_GAPS:    begin src_idle_pct = 82; sink_stall_pct = 0;  end
      FLOW_SINK_STALLS: begin src_idle_pct = 0;  sink_stall_pct = 82; end
      default:          begin src_idle_pct = 34; sink_stall_pct = 34; end
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] draw_half(coef_style_e style);
    logic [COEF_W-1:0] mag;
    int                bits;
    case (style)
      STYLE_MAX:  return 32'h7FFF_FFFF;
      STYLE_MIN:  return 32'h8000_0000;
      STYLE_FULL: return $urandom;
      default: begin
        bits = $urandom_range(4, 24);
        mag  = $urandom & ((32'd1 << bits) - 32'd1);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
      end
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] draw_time();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2, 3:    return $urandom_range(0, 32'h3FFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%s", msg);
    end
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] t,
                             logic signed [OUT_W-1:0] want, logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      note_error($sformatf("%s mismatch for t=%h: expected %h, got %h", name, t, want, got));
    end
  endtask

  // hold valid low until every outstanding request has returned
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_traj_q.size() != 0);
  endtask

  task automatic write_coef(coef_reg_e sel, logic [DATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(sel) * REG_STRIDE);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel <= COEF_POW0) begin
      coef_shadow[sel] = word;
    end
    // return the bus to idle
    @(posedge clk);
  endtask

  task automatic send_sample(logic [TIME_W-1:0] t, logic known, trajectory_t want);
    pending_t e;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.time_q <= t;
    do @(posedge clk); while (!in_ch.ready);
    e.t    = t;
    e.want = known ? want : eval_trajectory(t);
    expected_traj_q.push_back(e);
  endtask

  // ---- result checker -----------------------------------------------------

  initial begin : result_monitor
    pending_t due;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_traj_q.size() == 0) begin
          note_error("result arrived with no request outstanding");
        end else begin
          due = expected_traj_q.pop_front();
          check_field("pos_x", due.t, due.want.pos_x, out_ch.pos_x);
          check_field("pos_y", due.t, due.want.pos_y, out_ch.pos_y);
          check_field("vel_x", due.t, due.want.vel_x, out_ch.vel_x);
          check_field("vel_y", due.t, due.want.vel_y, out_ch.vel_y);
          check_field("acc_x", due.t, due.want.acc_x, out_ch.acc_x);
          check_field("acc_y", due.t, due.want.acc_y, out_ch.acc_y);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // ---- main sequence ------------------------------------------------------

  initial begin : stimulus
    coef_style_e style;
    coef_style_e style_y;
    trajectory_t zero_traj;
    zero_traj = '0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.time_q <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    foreach (coef_shadow[i]) coef_shadow[i] = '0;

    // coefficients are zero out of reset
    script.push_back(row_check(32'h0000_0000, zero_traj));
    script.push_back(row_check(32'hFFFF_FFFF, zero_traj));
    // largest t^5 term overflows every lane
    script.push_back(row_write(COEF_POW5, 64'h7FFF_FFFF_8000_0000));
    script.push_back(row_check(32'hFFFF_FFFF,
                               '{SAT_HI, SAT_LO, SAT_HI, SAT_LO, SAT_HI, SAT_LO}));
    script.push_back(row_check(32'h0000_0000, zero_traj));
    script.push_back(row_sample(32'h4000_0000));
    script.push_back(row_write(COEF_POW5, 64'h8000_0000_7FFF_FFFF));
    script.push_back(row_check(32'hFFFF_FFFF,
                               '{SAT_LO, SAT_HI, SAT_LO, SAT_HI, SAT_LO, SAT_HI}));
    // constant term alone passes straight through at any time
    script.push_back(row_write(COEF_POW5, 64'h0));
    script.push_back(row_write(COEF_POW0, 64'h7FFF_FFFF_8000_0000));
    script.push_back(row_check(32'h0000_0000, '{48'h007F_FFFF_FF00, 48'hFF80_0000_0000,
                                                48'h0, 48'h0, 48'h0, 48'h0}));
    script.push_back(row_check(32'hFFFF_FFFF, '{48'h007F_FFFF_FF00, 48'hFF80_0000_0000,
                                                48'h0, 48'h0, 48'h0, 48'h0}));
    // at t = 0: velocity is c1, acceleration is 2*c2
    script.push_back(row_write(COEF_POW1, 64'h0001_0000_FFFF_0000));
    script.push_back(row_write(COEF_POW2, 64'hFFFE_8000_0000_8000));
    script.push_back(row_check(32'h0000_0000, '{48'h007F_FFFF_FF00, 48'hFF80_0000_0000,
                                                48'h0000_0100_0000, 48'hFFFF_FF00_0000,
                                                48'hFFFF_FD00_0000, 48'h0000_0100_0000}));
    script.push_back(row_write(COEF_POW3, 64'h0001_2345_FFFE_DCBA));
    script.push_back(row_write(COEF_POW4, 64'h0000_4000_FFFF_C000));
    script.push_back(row_sample(32'h0000_0001));
    script.push_back(row_sample(32'h4000_0000));
    script.push_back(row_sample(32'h8000_0000));
    script.push_back(row_sample(32'hC000_0000));
    script.push_back(row_sample(32'h5555_5555));
    script.push_back(row_sample(32'hAAAA_AAAA));
    script.push_back(row_sample(32'h2000_0000));
    // writes past the last register must leave the coefficients alone
    script.push_back(row_write(COEF_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF));
    script.push_back(row_write(COEF_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF));
    script.push_back(row_sample(32'h4000_0000));
    script.push_back(row_sample(32'hFFFF_FFFF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_flow(FLOW_STEADY);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        wait_drained();
        write_coef(script[i].sel, script[i].word);
      end else begin
        send_sample(script[i].t, script[i].known, script[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      set_flow(flow_mode_e'(phase % 4));
      for (int r = 0; r < COEF_SLOTS; r++) begin
        if (phase == 0) begin
          style   = STYLE_MAX;
          style_y = STYLE_MAX;
        end else if (phase == 1) begin
          style   = STYLE_MIN;
          style_y = STYLE_MIN;
        end else begin
          style   = ($urandom_range(0, 9) < 7) ? STYLE_SMALL : STYLE_FULL;
          style_y = ($urandom_range(0, 9) < 7) ? STYLE_SMALL : STYLE_FULL;
        end
        write_coef(coef_reg_e'(r), {draw_half(style), draw_half(style_y)});
      end
      if ($urandom_range(0, 2) == 0) begin
        write_coef(($urandom_range(0, 1) == 1) ? COEF_SPARE6 : COEF_SPARE7,
                   {$urandom, $urandom});
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // let the pipeline empty completely partway through odd phases
        if (phase % 2 == 1 && n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_sample(draw_time(), 1'b0, zero_traj);
      end
    end

    wait_drained();
    repeat (2 * LATENCY_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_traj_q.size() == 0) begin
      $display("** quintic_trajectory_evaluator_top: PASSED **");
    end else begin
      $display("** quintic_trajectory_evaluator_top: FAILED **");
    end
    $finish;
  end

endmodule

[quintic_trajectory_evaluator_top.f]
+incdir+rtl
rtl/qte_pkg.sv
rtl/qte_if.sv
rtl/qte_horner_step.sv
rtl/quintic_trajectory_evaluator_top.sv
tb/quintic_trajectory_evaluator_top_test.sv
